// File: hdl/page_refcount_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the page reference-count allocator modules.
// ---------------------------------------------------------------------------
`ifndef PAGE_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_REFCOUNT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pra_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pra_pkg
// Shared types, field widths and codes of the page reference-count allocator.
// ---------------------------------------------------------------------------
package pra_pkg;

  localparam int NUM_PAGES_DEFAULT = 16384;

  localparam int KIND_W    = 3;
  localparam int PAGE_W    = 14;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int REG_W     = 15;
  localparam int REG_IDX_W = 2;

  // One bitmap word covers MAP_W pages; one summary word covers MAP_W bitmap words.
  localparam int MAP_SHIFT = 6;
  localparam int MAP_W     = 1 << MAP_SHIFT;
  localparam int SUM_SHIFT = 2 * MAP_SHIFT;

  localparam logic [KIND_W-1:0] KIND_ALLOC_USER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC_KERNEL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SHARE        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREE         = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET          = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_PROTECTED    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED    = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_OBJECT_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_END   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USER_END     = 2'd2;

  localparam logic [REG_W-1:0] OBJECT_START_RESET = 15'd0;
  localparam logic [REG_W-1:0] KERNEL_END_RESET   = 15'd0;
  localparam logic [REG_W-1:0] USER_END_RESET     = 15'd16384;

  localparam logic [COUNT_W-1:0] COUNT_ZERO     = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE      = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESERVED = 8'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic page_read;
    logic page_update;
    logic sum_read;
    logic sum_advance;
    logic bm_read;
    logic bm_advance;
    logic alloc_claim;
    logic alloc_fail;
    logic out_load;
  } pra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic in_alloc;
    logic search_done;
    logic sum_hit;
    logic bm_hit;
  } pra_status_t;

endpackage

// File: hdl/page_refcount_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_refcount_allocator
// Per-page 8-bit reference counts with lowest-free allocation per region.
// ---------------------------------------------------------------------------
// Usage: an input transaction (kind, page_index, set_value) is taken on the
// in_valid/in_ready handshake and yields exactly one result transaction
// (result_page, ref_count, status) on out_valid/out_ready. The user must write
// the region registers through cfg_write/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this. Share, free, query
// and set read the count RAM in S_PAGE_RD, write it back in S_PAGE_EXEC and
// load the output register in S_DONE. An allocation walks S_SCAN, S_SUM_CHK,
// S_BM_CHK and S_DONE when the first summary word it looks at leads to a free
// page; each further summary word adds S_SCAN and S_SUM_CHK, each further
// bitmap word S_SCAN, S_SUM_CHK and S_BM_CHK. An empty region goes from
// S_SCAN to S_DONE. No new transaction is taken until the block is back in
// S_IDLE. The summary bitmap (one bit per 64-page word, 4096 pages per
// summary word) sets the length of that walk. After reset a clearing pass
// over NUM_PAGES pages (16384 by default) marks every page reserved; in_ready
// stays low meanwhile. A stalled receiver holds the result in the output
// register; the block may take the next transaction and then waits with it.
// ---------------------------------------------------------------------------
module page_refcount_allocator #(
  parameter int NUM_PAGES = pra_pkg::NUM_PAGES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pra_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pra_pkg::REG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pra_pkg::KIND_W-1:0]      kind,
  input  logic [pra_pkg::PAGE_W-1:0]      page_index,
  input  logic [pra_pkg::COUNT_W-1:0]     set_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pra_pkg::PAGE_W-1:0]      result_page,
  output logic [pra_pkg::COUNT_W-1:0]     ref_count,
  output logic [pra_pkg::STATUS_W-1:0]    status
);
  import pra_pkg::*;

  // The controller only sequences; every map access, region compare and
  // result computation lives in the datapath.
  pra_cmd_t    cmd;
  pra_status_t stat;

  pra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the count map, the free bitmap and its summary, each
  // in its own RAM, so a free page is found by one summary read and one
  // bitmap read in the common case.
  pra_datapath #(.NUM_PAGES(NUM_PAGES)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .page_index  (page_index),
    .set_value   (set_value),
    .cmd         (cmd),
    .stat        (stat),
    .result_page (result_page),
    .ref_count   (ref_count),
    .status      (status)
  );

endmodule

// File: hdl/pra_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pra_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/pra_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pra_ctrl
// Sequencer: clearing pass, page operations and the two-level free search.
// ---------------------------------------------------------------------------
`include "page_refcount_allocator_macros.svh"

module pra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pra_pkg::pra_cmd_t    cmd,
  input  pra_pkg::pra_status_t stat
);
  import pra_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAGE_RD,
    S_PAGE_EXEC,
    S_SCAN,
    S_SUM_CHK,
    S_BM_CHK,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   load_ok;

  assign in_ready = (state == S_IDLE);
  assign load_ok  = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.in_alloc ? S_SCAN : S_PAGE_RD;
        end
      end
      S_PAGE_RD: begin
        cmd.page_read = 1'b1;
        state_next    = S_PAGE_EXEC;
      end
      S_PAGE_EXEC: begin
        cmd.page_update = 1'b1;
        state_next      = S_DONE;
      end
      S_SCAN: begin
        if (stat.search_done) begin
          cmd.alloc_fail = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.sum_read = 1'b1;
          state_next   = S_SUM_CHK;
        end
      end
      S_SUM_CHK: begin
        if (stat.sum_hit) begin
          cmd.bm_read = 1'b1;
          state_next  = S_BM_CHK;
        end else begin
          cmd.sum_advance = 1'b1;
          state_next      = S_SCAN;
        end
      end
      S_BM_CHK: begin
        if (stat.bm_hit) begin
          cmd.alloc_claim = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.bm_advance = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_DONE: begin
        if (load_ok) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PRA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, state != S_IDLE, "block stayed idle after taking a transaction")
  `PRA_ASSERT_IMPL(a_no_result_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready, "pending result overwritten")
  `PRA_ASSERT_IMPL(a_single_writer, clk, rst, 1'b1, ($onehot0({cmd.clear_step, cmd.alloc_claim, cmd.page_update})), "two map writers active at once")

endmodule

// File: hdl/pra_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pra_datapath
// Count map, free bitmap and summary bitmap, region registers and result path.
// ---------------------------------------------------------------------------
`include "page_refcount_allocator_macros.svh"

module pra_datapath #(
  parameter int NUM_PAGES = pra_pkg::NUM_PAGES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pra_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pra_pkg::REG_W-1:0]       cfg_data,
  input  logic [pra_pkg::KIND_W-1:0]      kind,
  input  logic [pra_pkg::PAGE_W-1:0]      page_index,
  input  logic [pra_pkg::COUNT_W-1:0]     set_value,
  input  pra_pkg::pra_cmd_t                cmd,
  output pra_pkg::pra_status_t             stat,
  output logic [pra_pkg::PAGE_W-1:0]      result_page,
  output logic [pra_pkg::COUNT_W-1:0]     ref_count,
  output logic [pra_pkg::STATUS_W-1:0]    status
);
  import pra_pkg::*;

  localparam int AW  = $clog2(NUM_PAGES);
  localparam int NW  = (NUM_PAGES + MAP_W - 1) / MAP_W;
  localparam int NS  = (NW + MAP_W - 1) / MAP_W;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int SAW = (NS > 1) ? $clog2(NS) : 1;
  localparam int XW  = ((AW > REG_W) ? AW : REG_W) + 1;

  function automatic logic [MAP_SHIFT-1:0] lowest_bit(input logic [MAP_W-1:0] v);
    logic [MAP_SHIFT-1:0] idx;
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = MAP_SHIFT'(i);
      end
    end
    return idx;
  endfunction

  // Region registers.
  logic [REG_W-1:0] object_start_page, kernel_end_page, user_end_page;

  // Captured item and search state.
  logic [KIND_W-1:0]  cap_kind;
  logic [PAGE_W-1:0]  cap_page;
  logic [COUNT_W-1:0] cap_value;
  logic [XW-1:0]      ptr, search_hi, hit_word;
  logic [AW-1:0]      clr_cnt;
  logic [PAGE_W-1:0]  res_page;
  logic [COUNT_W-1:0] res_count;
  logic [STATUS_W-1:0] res_status;

  // RAM ports.
  logic               cnt_we, cnt_re;
  logic [AW-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
  logic               bm_we, bm_re;
  logic [WAW-1:0]     bm_waddr, bm_raddr;
  logic [MAP_W-1:0]   bm_wdata, bm_rdata;
  logic               sum_we, sum_re;
  logic [SAW-1:0]     sum_waddr, sum_raddr;
  logic [MAP_W-1:0]   sum_wdata, sum_rdata;

  // Search logic.
  logic [REG_W-1:0]     lo_sel, hi_sel;
  logic [XW-1:0]        hi_clamp, hi_last, word_sel, found_page;
  logic                 sum_same, bm_first, bm_last;
  logic [MAP_SHIFT-1:0] sum_lo_j, sum_hi_j, sum_j, bm_lo_k, bm_hi_k, bm_k;
  logic [MAP_W-1:0]     sum_mask, sum_cand, bm_mask, bm_cand, claim_word, claim_sum;

  // Page operation logic.
  logic                 page_in_range, page_protected, zero_flip, new_zero;
  logic [COUNT_W-1:0]   upd_count;
  logic [STATUS_W-1:0]  upd_status;
  logic [MAP_W-1:0]     upd_word, upd_sum, page_bit, word_bit;
  logic                 clr_in_bm, clr_in_sum;

  pra_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  pra_ram #(.WIDTH(MAP_W), .DEPTH(NW)) u_bitmap_ram (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  pra_ram #(.WIDTH(MAP_W), .DEPTH(NS)) u_summary_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata)
  );

  // Region selection at capture time.
  assign lo_sel   = (kind == KIND_ALLOC_USER) ? kernel_end_page : object_start_page;
  assign hi_sel   = (kind == KIND_ALLOC_USER) ? user_end_page : kernel_end_page;
  assign hi_clamp = (XW'(hi_sel) > XW'(NUM_PAGES)) ? XW'(NUM_PAGES) : XW'(hi_sel);
  assign hi_last  = search_hi - XW'(1);

  // Summary word check: lowest bitmap word with a free page inside the region.
  assign sum_lo_j = ptr[SUM_SHIFT-1:MAP_SHIFT];
  assign sum_hi_j = hi_last[SUM_SHIFT-1:MAP_SHIFT];
  assign sum_same = (hi_last >> SUM_SHIFT) == (ptr >> SUM_SHIFT);

  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      sum_mask[j] = (MAP_SHIFT'(j) >= sum_lo_j) && (!sum_same || (MAP_SHIFT'(j) <= sum_hi_j));
    end
  end

  assign sum_cand = sum_rdata & sum_mask;
  assign sum_j    = lowest_bit(sum_cand);
  assign word_sel = ((ptr >> SUM_SHIFT) << MAP_SHIFT) | XW'(sum_j);

  // Bitmap word check: lowest free page of the chosen word inside the region.
  assign bm_first = (hit_word == (ptr >> MAP_SHIFT));
  assign bm_last  = (hit_word == (hi_last >> MAP_SHIFT));
  assign bm_lo_k  = bm_first ? ptr[MAP_SHIFT-1:0] : '0;
  assign bm_hi_k  = bm_last ? hi_last[MAP_SHIFT-1:0] : '1;

  always_comb begin
    for (int k = 0; k < MAP_W; k++) begin
      bm_mask[k] = (MAP_SHIFT'(k) >= bm_lo_k) && (MAP_SHIFT'(k) <= bm_hi_k);
    end
  end

  assign bm_cand    = bm_rdata & bm_mask;
  assign bm_k       = lowest_bit(bm_cand);
  assign found_page = (hit_word << MAP_SHIFT) | XW'(bm_k);
  assign claim_word = bm_rdata & ~(MAP_W'(1) << bm_k);
  assign claim_sum  = sum_rdata & ~(MAP_W'(1) << hit_word[MAP_SHIFT-1:0]);

  // Share, free, query and set.
  assign page_in_range  = XW'(cap_page) < XW'(NUM_PAGES);
  assign page_protected = REG_W'(cap_page) < object_start_page;

  always_comb begin
    upd_count  = cnt_rdata;
    upd_status = STATUS_OK;
    unique case (cap_kind)
      KIND_SHARE: begin
        if (page_protected) begin
          upd_status = STATUS_PROTECTED;
        end else if (cnt_rdata == COUNT_MAX) begin
          upd_status = STATUS_SATURATED;
        end else begin
          upd_count = cnt_rdata + COUNT_ONE;
        end
      end
      KIND_FREE: begin
        if (page_protected) begin
          upd_status = STATUS_PROTECTED;
        end else if (cnt_rdata == COUNT_ZERO) begin
          upd_status = STATUS_ALREADY_FREE;
        end else begin
          upd_count = cnt_rdata - COUNT_ONE;
        end
      end
      KIND_SET: begin
        upd_count = cap_value;
      end
      default: begin
        upd_count = cnt_rdata;
      end
    endcase
  end

  assign new_zero  = (upd_count == COUNT_ZERO);
  assign zero_flip = (cnt_rdata == COUNT_ZERO) != new_zero;
  assign page_bit  = MAP_W'(1) << cap_page[MAP_SHIFT-1:0];
  assign word_bit  = MAP_W'(1) << cap_page[SUM_SHIFT-1:MAP_SHIFT];
  assign upd_word  = new_zero ? (bm_rdata | page_bit) : (bm_rdata & ~page_bit);
  assign upd_sum   = (|upd_word) ? (sum_rdata | word_bit) : (sum_rdata & ~word_bit);

  assign clr_in_bm  = (AW + 1)'(clr_cnt) < (AW + 1)'(NW);
  assign clr_in_sum = (AW + 1)'(clr_cnt) < (AW + 1)'(NS);

  // Memory port selection.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = AW'(cap_page);
    cnt_wdata = upd_count;
    bm_we     = 1'b0;
    bm_waddr  = WAW'(cap_page >> MAP_SHIFT);
    bm_wdata  = upd_word;
    sum_we    = 1'b0;
    sum_waddr = SAW'(cap_page >> SUM_SHIFT);
    sum_wdata = upd_sum;
    priority if (cmd.clear_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_cnt;
      cnt_wdata = COUNT_RESERVED;
      bm_we     = clr_in_bm;
      bm_waddr  = WAW'(clr_cnt);
      bm_wdata  = '0;
      sum_we    = clr_in_sum;
      sum_waddr = SAW'(clr_cnt);
      sum_wdata = '0;
    end else if (cmd.alloc_claim) begin
      cnt_we    = 1'b1;
      cnt_waddr = AW'(found_page);
      cnt_wdata = COUNT_ONE;
      bm_we     = 1'b1;
      bm_waddr  = WAW'(hit_word);
      bm_wdata  = claim_word;
      sum_we    = (claim_word == '0);
      sum_waddr = SAW'(hit_word >> MAP_SHIFT);
      sum_wdata = claim_sum;
    end else if (cmd.page_update) begin
      cnt_we = page_in_range;
      bm_we  = page_in_range && zero_flip;
      sum_we = page_in_range && zero_flip;
    end else begin
      cnt_we = 1'b0;
    end
  end

  assign cnt_re    = cmd.page_read;
  assign cnt_raddr = AW'(cap_page);
  assign bm_re     = cmd.page_read || cmd.bm_read;
  assign bm_raddr  = cmd.bm_read ? WAW'(word_sel) : WAW'(cap_page >> MAP_SHIFT);
  assign sum_re    = cmd.page_read || cmd.sum_read;
  assign sum_raddr = cmd.sum_read ? SAW'(ptr >> SUM_SHIFT) : SAW'(cap_page >> SUM_SHIFT);

  assign stat.clear_last  = (clr_cnt == AW'(NUM_PAGES - 1));
  assign stat.in_alloc    = (kind == KIND_ALLOC_USER) || (kind == KIND_ALLOC_KERNEL);
  assign stat.search_done = (ptr >= search_hi);
  assign stat.sum_hit     = |sum_cand;
  assign stat.bm_hit      = |bm_cand;

  // Control registers: region settings and the clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      object_start_page <= OBJECT_START_RESET;
      kernel_end_page   <= KERNEL_END_RESET;
      user_end_page     <= USER_END_RESET;
      clr_cnt           <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_OBJECT_START: object_start_page <= cfg_data;
          REG_KERNEL_END:   kernel_end_page   <= cfg_data;
          REG_USER_END:     user_end_page     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_kind  <= kind;
      cap_page  <= page_index;
      cap_value <= set_value;
      ptr       <= XW'(lo_sel);
      search_hi <= hi_clamp;
    end
    if (cmd.sum_advance) begin
      ptr <= ((ptr >> SUM_SHIFT) + XW'(1)) << SUM_SHIFT;
    end
    if (cmd.bm_advance) begin
      ptr <= (hit_word + XW'(1)) << MAP_SHIFT;
    end
    if (cmd.bm_read) begin
      hit_word <= word_sel;
    end
    if (cmd.alloc_claim) begin
      res_page   <= PAGE_W'(found_page);
      res_count  <= COUNT_ONE;
      res_status <= STATUS_OK;
    end
    if (cmd.alloc_fail) begin
      res_page   <= '0;
      res_count  <= COUNT_ZERO;
      res_status <= STATUS_NO_FREE;
    end
    if (cmd.page_update) begin
      res_page   <= cap_page;
      res_count  <= page_in_range ? upd_count : COUNT_ZERO;
      res_status <= page_in_range ? upd_status : STATUS_PROTECTED;
    end
    if (cmd.out_load) begin
      result_page <= res_page;
      ref_count   <= res_count;
      status      <= res_status;
    end
  end

  `PRA_ASSERT_IMPL(a_scan_below_end, clk, rst, cmd.sum_read, ptr < search_hi, "summary read past region end")
  `PRA_ASSERT_NEXT(a_word_in_region, clk, rst, cmd.bm_read, (hit_word >= (ptr >> MAP_SHIFT)) && (hit_word <= (hi_last >> MAP_SHIFT)), "bitmap word outside region")
  `PRA_ASSERT_IMPL(a_claim_in_region, clk, rst, cmd.alloc_claim, (found_page >= ptr) && (found_page < search_hi), "claimed page outside region")

endmodule
